@@ design/oaht_pkg.sv @@
// Shared types and constants for the open-addressing hash table.
`timescale 1ns / 1ps
`default_nettype none
package oaht_pkg;

  localparam int unsigned DEF_CAPACITY = 64;

  localparam int unsigned MODE_W = 2;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned HASH_W = 32;
  localparam int unsigned VAL_W  = 64;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned CNT_W  = 7;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [CNT_W-1:0] DEF_MAX_ENTRIES = 7'd48;
  localparam logic             REG_MAX_ENTRIES = 1'b0;

  localparam logic [MODE_W-1:0] MODE_GET = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SET = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEL = 2'd2;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_OCC   = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  localparam logic RES_DONE = 1'b0;
  localparam logic RES_FULL = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic hash_step;
    logic probe_start;
    logic probe_step;
    logic commit;
    logic clr_step;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic mod_done;
    logic probe_end;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

@@ design/oaht_ctrl.sv @@
// Sequencer for the hash table: clear pass, hash reduction, probe and commit.
`timescale 1ns / 1ps
`default_nettype none
module oaht_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output oaht_pkg::dp_cmd_t cmd,
  input  oaht_pkg::dp_sts_t sts
);
  import oaht_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_HASH;
      end
      S_HASH: begin
        if (sts.mod_done) state_nxt = S_PROBE;
      end
      S_PROBE: begin
        if (sts.probe_end) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_HASH: begin
        cmd.probe_start = sts.mod_done;
        cmd.hash_step   = !sts.mod_done;
      end
      S_PROBE: begin
        cmd.probe_step = 1'b1;
      end
      S_COMMIT: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.hash_step, cmd.probe_start, cmd.probe_step, cmd.commit,
              cmd.clr_step}))
    else $error("more than one datapath command at once");

  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (state_r == S_IDLE) && !in_stall)
    else $error("commit not followed by idle");

  a_load_hash: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_HASH) && in_stall)
    else $error("accepted request did not start hashing");

endmodule
`default_nettype wire

@@ design/oaht_dp.sv @@
// Datapath: slot memories, hash reduction, probe walk, commit decision, output and config regs.
`timescale 1ns / 1ps
`default_nettype none
module oaht_dp #(
  parameter int unsigned CAPACITY = oaht_pkg::DEF_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  oaht_pkg::dp_cmd_t             cmd,
  output oaht_pkg::dp_sts_t             sts,
  input  logic [oaht_pkg::MODE_W-1:0]   in_mode,
  input  logic [oaht_pkg::KEY_W-1:0]    in_key_id,
  input  logic [oaht_pkg::HASH_W-1:0]   in_key_hash,
  input  logic [oaht_pkg::VAL_W-1:0]    in_value_in,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [oaht_pkg::ADDR_W-1:0]   paddr,
  input  logic [oaht_pkg::DATA_W-1:0]   pwdata,
  output logic [oaht_pkg::DATA_W-1:0]   prdata,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic [oaht_pkg::VAL_W-1:0]    out_value_out,
  output logic [oaht_pkg::SLOT_W-1:0]   out_slot_index,
  output logic                          out_status
);
  import oaht_pkg::*;

  localparam int unsigned IDX_W     = $clog2(CAPACITY);
  localparam bit          IS_POW2   = (CAPACITY & (CAPACITY - 1)) == 0;
  localparam int unsigned MOD_BITS  = 8;
  localparam int unsigned MOD_STEPS = HASH_W / MOD_BITS;
  localparam int unsigned MCNT_W    = $clog2(MOD_STEPS);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [IDX_W:0]    CAP_EXT  = (IDX_W + 1)'(CAPACITY);
  localparam logic [MCNT_W-1:0] LAST_MOD = MCNT_W'(MOD_STEPS - 1);

  logic [1:0]       status_mem [CAPACITY];
  logic [KEY_W-1:0] key_mem    [CAPACITY];
  logic [VAL_W-1:0] val_mem    [CAPACITY];

  logic [MODE_W-1:0] mode_r;
  logic [KEY_W-1:0]  key_r;
  logic [HASH_W-1:0] hash_r;
  logic [VAL_W-1:0]  val_r;
  logic [IDX_W-1:0]  rem_r;
  logic [MCNT_W-1:0] mod_cnt_r;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  idx_nxt;
  logic [IDX_W-1:0]  n_r;
  logic              tomb_v_r;
  logic [IDX_W-1:0]  tomb_idx_r;
  logic              fnd_r;
  logic              emp_r;
  logic [1:0]        rd_st_r;
  logic [KEY_W-1:0]  rd_key_r;
  logic [VAL_W-1:0]  rd_val_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  max_r;
  logic [IDX_W-1:0]  clr_idx_r;

  logic              out_valid_r;
  logic              out_hit_r;
  logic [VAL_W-1:0]  out_value_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_status_r;

  logic [IDX_W-1:0]  rem_calc;
  logic              slot_match;
  logic              slot_empty;
  logic              probe_end;
  logic              room;

  logic              res_hit;
  logic              res_status;
  logic [VAL_W-1:0]  res_vout;
  logic [IDX_W-1:0]  res_slot;
  logic [IDX_W+5:0]  res_slot_wide;
  logic              wr_st;
  logic              wr_key;
  logic              wr_val;
  logic [1:0]        st_data;
  logic [IDX_W-1:0]  wr_slot;
  logic              cnt_inc;

  logic              st_we;
  logic              key_we;
  logic              val_we;
  logic [1:0]        st_wd;
  logic [IDX_W-1:0]  wr_addr;
  logic              cfg_we;

  // hash mod CAPACITY, MOD_BITS hash bits per step
  always_comb begin
    logic [IDX_W:0]   t;
    logic [IDX_W-1:0] acc;
    acc = rem_r;
    for (int i = 0; i < MOD_BITS; i++) begin
      t = {acc, hash_r[HASH_W-1-i]};
      if (t >= CAP_EXT) t = t - CAP_EXT;
      acc = t[IDX_W-1:0];
    end
    rem_calc = IS_POW2 ? hash_r[IDX_W-1:0] : acc;
  end

  assign slot_empty = (rd_st_r == SLOT_EMPTY);
  assign slot_match = (rd_st_r == SLOT_OCC) && (rd_key_r == key_r);
  assign probe_end  = slot_empty || slot_match || (n_r == LAST_IDX);
  assign room       = ({1'b0, count_r} + (CNT_W + 1)'(1)) <= {1'b0, max_r};

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.probe_start) begin
      idx_nxt = rem_calc;
    end else if (cmd.probe_step && !probe_end) begin
      idx_nxt = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
    end
  end

  always_comb begin
    res_hit    = 1'b0;
    res_status = RES_DONE;
    res_vout   = '0;
    res_slot   = '0;
    wr_st      = 1'b0;
    wr_key     = 1'b0;
    wr_val     = 1'b0;
    st_data    = SLOT_OCC;
    wr_slot    = idx_r;
    cnt_inc    = 1'b0;
    case (mode_r)
      MODE_GET: begin
        if (fnd_r) begin
          res_hit  = 1'b1;
          res_slot = idx_r;
          res_vout = rd_val_r;
        end
      end
      MODE_DEL: begin
        if (fnd_r) begin
          res_hit  = 1'b1;
          res_slot = idx_r;
          wr_st    = 1'b1;
          st_data  = SLOT_TOMB;
        end
      end
      MODE_SET: begin
        if (fnd_r) begin
          res_slot = idx_r;
          wr_val   = 1'b1;
        end else if (tomb_v_r) begin
          res_hit  = 1'b1;
          res_slot = tomb_idx_r;
          wr_slot  = tomb_idx_r;
          wr_st    = 1'b1;
          wr_key   = 1'b1;
          wr_val   = 1'b1;
        end else if (emp_r && room) begin
          res_hit  = 1'b1;
          res_slot = idx_r;
          wr_st    = 1'b1;
          wr_key   = 1'b1;
          wr_val   = 1'b1;
          cnt_inc  = 1'b1;
        end else begin
          res_status = RES_FULL;
        end
      end
      default: begin
        res_hit = 1'b0;
      end
    endcase
  end

  assign res_slot_wide = {{SLOT_W{1'b0}}, res_slot};

  assign st_we   = cmd.clr_step || (cmd.commit && wr_st);
  assign key_we  = cmd.commit && wr_key;
  assign val_we  = cmd.commit && wr_val;
  assign st_wd   = cmd.clr_step ? SLOT_EMPTY : st_data;
  assign wr_addr = cmd.clr_step ? clr_idx_r : wr_slot;

  always_ff @(posedge clk) begin
    if (st_we)  status_mem[wr_addr] <= st_wd;
    if (key_we) key_mem[wr_addr]    <= key_r;
    if (val_we) val_mem[wr_addr]    <= val_r;
    rd_st_r  <= status_mem[idx_nxt];
    rd_key_r <= key_mem[idx_nxt];
    rd_val_r <= val_mem[idx_nxt];
  end

  // request capture, hash reduction and probe walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= in_mode;
      key_r     <= in_key_id;
      hash_r    <= in_key_hash;
      val_r     <= in_value_in;
      rem_r     <= '0;
      mod_cnt_r <= '0;
    end
    if (cmd.hash_step) begin
      rem_r     <= rem_calc;
      hash_r    <= hash_r << MOD_BITS;
      mod_cnt_r <= mod_cnt_r + 1'b1;
    end
    if (cmd.probe_start) begin
      n_r      <= '0;
      tomb_v_r <= 1'b0;
    end
    if (cmd.probe_step) begin
      if (!tomb_v_r && (rd_st_r == SLOT_TOMB)) begin
        tomb_v_r   <= 1'b1;
        tomb_idx_r <= idx_r;
      end
      if (probe_end) begin
        fnd_r <= slot_match;
        emp_r <= slot_empty;
      end else begin
        n_r <= n_r + 1'b1;
      end
    end
    idx_r <= idx_nxt;
  end

  assign cfg_we = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_MAX_ENTRIES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      max_r       <= DEF_MAX_ENTRIES;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) max_r <= pwdata[CNT_W-1:0];
      if (cmd.commit && cnt_inc) count_r <= count_r + 1'b1;
      if (cmd.clr_step) clr_idx_r <= clr_idx_r + 1'b1;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit_r    <= res_hit;
      out_value_r  <= res_vout;
      out_slot_r   <= res_slot_wide[SLOT_W-1:0];
      out_status_r <= res_status;
    end
  end

  assign prdata = (paddr[ADDR_W-1] == REG_MAX_ENTRIES) ? DATA_W'(max_r) : '0;

  assign sts.clr_done  = (clr_idx_r == LAST_IDX);
  assign sts.mod_done  = IS_POW2 || (mod_cnt_r == LAST_MOD);
  assign sts.probe_end = probe_end;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_value_out  = out_value_r;
  assign out_slot_index = out_slot_r;
  assign out_status     = out_status_r;

  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> count_r >= $past(count_r))
    else $error("occupancy count went down");

  a_count_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r != $past(count_r)) |-> $past(cmd.commit))
    else $error("occupancy count changed outside a commit");

  a_hit_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && (out_status_r == RES_FULL)))
    else $error("refused set reported as hit");

  a_value_get: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_value_r != '0) |-> out_hit_r)
    else $error("value returned without a hit");

endmodule
`default_nettype wire

@@ design/open_addressing_hash_table.sv @@
// Top level of the linear-probing hash table with tombstones.
//
// Requests (get, set, delete) arrive on in_valid/in_stall with key id, key
// hash and value; one result per request leaves on out_valid/out_stall.
// A request is taken only while the block is idle; in_stall is high while
// one is in flight.
// Per request: an accept step, a hash-reduce phase (the low hash bits when CAPACITY
// is a power of two, else a mod reduction of 8 hash bits per step), the probe
// walk over the slots, then a commit step.
// The probe walk reads one slot per cycle from the slot memories; that port
// sets the rate.
// After reset the slot status memory is swept to empty, one slot per cycle, with
// in_stall held high; config writes are taken meanwhile.
// max_entries resets to 48 and lives at APB byte address 0.
// The result sits in an output register; a stalled receiver holds it, the
// next request may still be accepted, and its commit waits until the output
// register frees up.
`timescale 1ns / 1ps
`default_nettype none
module open_addressing_hash_table #(
  parameter int unsigned CAPACITY = oaht_pkg::DEF_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [oaht_pkg::MODE_W-1:0] in_mode,
  input  logic [oaht_pkg::KEY_W-1:0]  in_key_id,
  input  logic [oaht_pkg::HASH_W-1:0] in_key_hash,
  input  logic [oaht_pkg::VAL_W-1:0]  in_value_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_hit,
  output logic [oaht_pkg::VAL_W-1:0]  out_value_out,
  output logic [oaht_pkg::SLOT_W-1:0] out_slot_index,
  output logic                        out_status,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [oaht_pkg::ADDR_W-1:0] paddr,
  input  logic [oaht_pkg::DATA_W-1:0] pwdata,
  output logic [oaht_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import oaht_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign pready = 1'b1;

  oaht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  oaht_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_mode        (in_mode),
    .in_key_id      (in_key_id),
    .in_key_hash    (in_key_hash),
    .in_value_in    (in_value_in),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_value_out  (out_value_out),
    .out_slot_index (out_slot_index),
    .out_status     (out_status)
  );

endmodule
`default_nettype wire

@@ verif/open_addressing_hash_table_tb.sv @@
// Testbench for open_addressing_hash_table: shadow-table scoreboard, directed and random traffic.
`timescale 1ns / 1ps
module open_addressing_hash_table_tb;
  import oaht_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
  localparam int unsigned CAP = DEF_CAPACITY;
  localparam logic [ADDR_W-1:0] LIMIT_ADDR = ADDR_W'(4 * REG_MAX_ENTRIES);
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned NUM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 225;
  localparam int unsigned POOL_SIZE = 24;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned SETTLE_CYCLES = 80;

  typedef struct packed {
    logic              hit;
    logic [VAL_W-1:0]  value;
    logic [SLOT_W-1:0] slot;
    logic              status;
  } lookup_result_t;

  class hash_table_shadow;
    logic [1:0]       slot_state [CAP];
    logic [KEY_W-1:0] slot_owner [CAP];
    logic [VAL_W-1:0] slot_word [CAP];
    int unsigned      fill_count;
    int unsigned      load_limit;
    lookup_result_t   expected_results [$];
    int unsigned      mismatches;

    function new();
      foreach (slot_state[i]) begin
        slot_state[i] = SLOT_EMPTY;
        slot_owner[i] = '0;
        slot_word[i] = '0;
      end
      fill_count = 0;
      load_limit = DEF_MAX_ENTRIES;
      mismatches = 0;
    endfunction

    function void set_limit(logic [CNT_W-1:0] limit);
      load_limit = limit;
    endfunction

    // linear walk: stops at an empty slot or the key, remembers the first tombstone
    function void probe_slots(input logic [KEY_W-1:0] key, input logic [HASH_W-1:0] hash,
                              output int found, output int tomb, output int empty);
      int unsigned idx;
      int unsigned n;
      found = -1;
      tomb = -1;
      empty = -1;
      idx = hash % CAP;
      for (n = 0; n < CAP; n++) begin
        if (slot_state[idx] == SLOT_EMPTY) begin
          empty = idx;
          return;
        end
        if (slot_state[idx] == SLOT_TOMB) begin
          if (tomb < 0) tomb = idx;
        end else if (slot_owner[idx] == key) begin
          found = idx;
          return;
        end
        idx = (idx + 1) % CAP;
      end
    endfunction

    function void note_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                               logic [HASH_W-1:0] hash, logic [VAL_W-1:0] value);
      lookup_result_t res;
      int found, tomb, empty;
      res = '0;
      res.status = RES_DONE;
      if (mode == MODE_GET || mode == MODE_DEL) begin
        if (fill_count != 0) begin
          probe_slots(key, hash, found, tomb, empty);
          if (found >= 0) begin
            res.hit = 1'b1;
            res.slot = SLOT_W'(found);
            if (mode == MODE_GET) begin
              res.value = slot_word[found];
            end else begin
              slot_state[found] = SLOT_TOMB;
              slot_owner[found] = '0;
              slot_word[found] = '0;
            end
          end
        end
      end else if (mode == MODE_SET) begin
        probe_slots(key, hash, found, tomb, empty);
        if (found >= 0) begin
          slot_word[found] = value;
          res.slot = SLOT_W'(found);
        end else if (tomb >= 0) begin
          slot_state[tomb] = SLOT_OCC;
          slot_owner[tomb] = key;
          slot_word[tomb] = value;
          res.hit = 1'b1;
          res.slot = SLOT_W'(tomb);
        end else if (empty >= 0 && fill_count + 1 <= load_limit) begin
          slot_state[empty] = SLOT_OCC;
          slot_owner[empty] = key;
          slot_word[empty] = value;
          fill_count = (fill_count + 1) & 7'h7f;
          res.hit = 1'b1;
          res.slot = SLOT_W'(empty);
        end else begin
          res.status = RES_FULL;
        end
      end
      expected_results.push_back(res);
    endfunction

    function void check_result(lookup_result_t got);
      lookup_result_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result: hit=%0b value=%0h slot=%0d status=%0b",
               got.hit, got.value, got.slot, got.status);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (got.hit !== want.hit) begin
        $error("hit: expected %0b, actual %0b", want.hit, got.hit);
        mismatches++;
      end
      if (got.value !== want.value) begin
        $error("value_out: expected %0h, actual %0h", want.value, got.value);
        mismatches++;
      end
      if (got.slot !== want.slot) begin
        $error("slot_index: expected %0d, actual %0d", want.slot, got.slot);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0b, actual %0b", want.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [MODE_W-1:0] in_mode = MODE_GET;
  logic [KEY_W-1:0]  in_key_id = '0;
  logic [HASH_W-1:0] in_key_hash = '0;
  logic [VAL_W-1:0]  in_value_in = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_hit;
  logic [VAL_W-1:0]  out_value_out;
  logic [SLOT_W-1:0] out_slot_index;
  logic              out_status;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  hash_table_shadow shadow;
  int unsigned      cycle_count = 0;
  bit               quiet_sender = 1'b0;
  bit               quiet_receiver = 1'b0;
  bit               hold_request = 1'b0;
  int unsigned      hold_left = 0;
  int unsigned      result_gap = 0;

  logic [KEY_W-1:0]  pool_key [POOL_SIZE];
  logic [HASH_W-1:0] pool_hash [POOL_SIZE];
  logic [CNT_W-1:0]  phase_limit [NUM_PHASES] = '{7'd12, 7'd33, 7'd48, 7'd64, 7'd3, 7'd64};
  logic [HASH_W-1:0] hash_word;
  logic [MODE_W-1:0] pick_mode;
  int unsigned       cluster, roll, pick;

  open_addressing_hash_table dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_key_id     (in_key_id),
    .in_key_hash   (in_key_hash),
    .in_value_in   (in_value_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit       (out_hit),
    .out_value_out (out_value_out),
    .out_slot_index(out_slot_index),
    .out_status    (out_status),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: check at the edge, then pick the stall for the next cycles
  always begin
    @(posedge clk);
    if (rst_n && out_valid && !out_stall) begin
      shadow.check_result({out_hit, out_value_out, out_slot_index, out_status});
      result_gap = quiet_receiver ? 0 : $urandom_range(0, 10);
    end
    if (hold_request) begin
      hold_left = LONG_HOLD;
      hold_request = 1'b0;
    end
    @(negedge clk);
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (result_gap > 0) begin
      out_stall <= 1'b1;
      result_gap--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // called and returns at a falling edge; valid stays high when the next request follows at once
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                              input logic [HASH_W-1:0] hash, input logic [VAL_W-1:0] value);
    int unsigned gap;
    gap = quiet_sender ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_key_id <= key;
    in_key_hash <= hash;
    in_value_in <= value;
    do @(posedge clk); while (in_stall);
    shadow.note_request(mode, key, hash, value);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (shadow.expected_results.size() != 0) @(negedge clk);
  endtask

  // setup + access, then an idle phase with psel low; starts and ends at a falling edge
  task automatic apb_access(input logic wr, input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= LIMIT_ADDR;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_limit_reg(input logic [CNT_W-1:0] limit);
    logic [DATA_W-1:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd !== DATA_W'(limit)) begin
      $error("max_entries: expected %0d, actual %0d", limit, rd);
      shadow.mismatches++;
    end
  endtask

  task automatic program_limit(input logic [CNT_W-1:0] limit);
    logic [DATA_W-1:0] rd;
    apb_access(1'b1, DATA_W'(limit), rd);
    shadow.set_limit(limit);
    check_limit_reg(limit);
  endtask

  task automatic directed_requests();
    program_limit(7'd0);
    send_request(MODE_GET, 32'd5, 32'd0, 64'h1);
    send_request(MODE_DEL, 32'd5, 32'd0, 64'h2);
    send_request(MODE_SET, 32'd5, 32'd0, 64'h3);
    send_request(MODE_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
    drain();
    program_limit(7'd1);
    send_request(MODE_SET, 32'd0, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF);
    send_request(MODE_SET, 32'hFFFF_FFFF, 32'd63, 64'h5);
    send_request(MODE_SET, 32'd0, 32'hFFFF_FFFF, '1);
    send_request(MODE_GET, 32'd0, 32'hFFFF_FFFF, '0);
    send_request(MODE_DEL, 32'd0, 32'hFFFF_FFFF, '0);
    send_request(MODE_GET, 32'd0, 32'hFFFF_FFFF, '0);
    send_request(MODE_DEL, 32'd0, 32'hFFFF_FFFF, '0);
    send_request(MODE_SET, 32'hFFFF_FFFF, 32'd63, 64'hFEDC_BA98_7654_3210);
    drain();
    program_limit(7'd64);
    send_request(MODE_SET, 32'd7, 32'h0000_003F, '0);
    send_request(MODE_GET, 32'd7, 32'h0000_003F, '1);
    send_request(MODE_DEL, 32'd7, 32'h0000_003E, '0);
    send_request(MODE_SET, 32'd9, 32'hAAAA_AAC0, 64'h8000_0000_0000_0001);
    send_request(MODE_GET, 32'd9, 32'h5555_5540, '0);
    send_request(MODE_GET, 32'hFFFF_FFFF, 32'h0000_003F, '0);
    send_request(MODE_NOP, 32'd0, 32'd0, '0);
    drain();
  endtask

  task automatic refill_pool();
    cluster = $urandom_range(0, CAP - 1);
    foreach (pool_key[i]) begin
      hash_word = $urandom;
      // most keys crowd into a few neighboring slots to force long probe chains
      if (i % 4 != 3) hash_word[SLOT_W-1:0] = SLOT_W'(cluster + $urandom_range(0, 9));
      pool_key[i] = $urandom;
      pool_hash[i] = hash_word;
    end
  endtask

  initial begin
    shadow = new();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    check_limit_reg(DEF_MAX_ENTRIES);
    directed_requests();
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      program_limit(p == 4 ? CNT_W'($urandom_range(1, 16)) : phase_limit[p]);
      quiet_sender = (p % 2 == 1);
      quiet_receiver = (p % 3 == 1);
      if (p == 2) hold_request = 1'b1;
      refill_pool();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          send_request(MODE_W'($urandom_range(0, 3)), $urandom, $urandom,
                       {$urandom, $urandom});
        end else begin
          pick = $urandom_range(0, POOL_SIZE - 1);
          pick_mode = (roll < 45) ? MODE_SET : (roll < 75) ? MODE_GET : MODE_DEL;
          send_request(pick_mode, pool_key[pick], pool_hash[pick], {$urandom, $urandom});
        end
      end
    end
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (shadow.mismatches == 0 && shadow.expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
